// ===== hw/rtl/grr_pkg.sv =====
package grr_pkg;

	localparam int DATA_W = 32;
	localparam int CFG_W  = 7;

	typedef struct packed {
		logic signed [DATA_W-1:0] element_value;
		logic                     sequence_end;
	} grr_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] out_value;
		logic                     run_last;
		logic                     out_sequence_end;
	} grr_result_t;

	// Shift commands from the controller to every cell of the stack.
	typedef struct packed {
		logic push;
		logic pop;
	} grr_shift_t;

	// Handshake and result flags from the controller to the top level.
	typedef struct packed {
		logic busy;
		logic strobe;
		logic run_last;
		logic seq_end;
	} grr_status_t;

	typedef enum logic {
		ST_FILL,
		ST_DRAIN
	} grr_state_t;

endpackage

// ===== hw/rtl/grr_cell.sv =====
// One slot of the LIFO chain: loads from the left neighbor on a push and
// from the right neighbor on a pop.
module grr_cell (
	input  logic                              clk,
	input  grr_pkg::grr_shift_t               shift,
	input  logic signed [grr_pkg::DATA_W-1:0] from_left,
	input  logic signed [grr_pkg::DATA_W-1:0] from_right,
	output logic signed [grr_pkg::DATA_W-1:0] value
);

	logic signed [grr_pkg::DATA_W-1:0] value_q;

	always_ff @(posedge clk) begin
		if (shift.push) begin
			value_q <= from_left;
		end else if (shift.pop) begin
			value_q <= from_right;
		end
	end

	assign value = value_q;

endmodule

// ===== hw/rtl/grr_ctrl.sv =====
// Fill and drain sequencer: counts buffered elements, decides when a run
// flushes, and marks the results of a run.
module grr_ctrl #(
	parameter int MAX_GROUP = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       item_end,
	input  logic                       cfg_write,
	input  logic [grr_pkg::CFG_W-1:0]  cfg_data,
	output grr_pkg::grr_shift_t        shift,
	output grr_pkg::grr_status_t       status
);

	localparam int CW = $clog2(MAX_GROUP + 1);

	grr_pkg::grr_state_t        state_q, state_d;
	logic [CW-1:0]              count_q, count_d;
	logic [CW-1:0]              count_inc;
	logic                       last_q;
	logic [grr_pkg::CFG_W-1:0]  gsz_q;
	logic [grr_pkg::CFG_W-1:0]  eff_size;
	logic                       accept;
	logic                       flush;
	logic                       final_one;

	always_comb begin
		if (gsz_q == '0) begin
			eff_size = grr_pkg::CFG_W'(1);
		end else if (gsz_q > grr_pkg::CFG_W'(MAX_GROUP)) begin
			eff_size = grr_pkg::CFG_W'(MAX_GROUP);
		end else begin
			eff_size = gsz_q;
		end
	end

	assign accept    = (state_q == grr_pkg::ST_FILL) && start;
	assign count_inc = count_q + CW'(1);
	assign flush     = (grr_pkg::CFG_W'(count_inc) >= eff_size) || item_end;
	assign final_one = (state_q == grr_pkg::ST_DRAIN) && (count_q == CW'(1));

	// Next state and count.
	always_comb begin
		state_d = state_q;
		count_d = count_q;
		case (state_q)
			grr_pkg::ST_FILL: begin
				if (start) begin
					count_d = count_inc;
					if (flush) begin
						state_d = grr_pkg::ST_DRAIN;
					end
				end
			end
			grr_pkg::ST_DRAIN: begin
				count_d = count_q - CW'(1);
				if (count_q == CW'(1)) begin
					state_d = grr_pkg::ST_FILL;
				end
			end
			default: begin
				state_d = grr_pkg::ST_FILL;
				count_d = '0;
			end
		endcase
	end

	// Outputs.
	always_comb begin
		shift.push      = accept;
		shift.pop       = (state_q == grr_pkg::ST_DRAIN);
		status.busy     = (state_q == grr_pkg::ST_DRAIN);
		status.strobe   = (state_q == grr_pkg::ST_DRAIN);
		status.run_last = final_one;
		status.seq_end  = final_one && last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= grr_pkg::ST_FILL;
			count_q <= '0;
			last_q  <= 1'b0;
			gsz_q   <= grr_pkg::CFG_W'(1);
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (accept) begin
				last_q <= item_end;
			end
			if (cfg_write) begin
				gsz_q <= cfg_data;
			end
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_GROUP))
		else $error("buffered element count exceeds the stack depth");

	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == grr_pkg::ST_DRAIN) |-> (count_q != '0))
		else $error("draining with an empty stack");

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		final_one |=> (state_q == grr_pkg::ST_FILL) && (count_q == '0))
		else $error("run did not end after its last result");

	a_fill_below_size: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !flush) |=> (state_q == grr_pkg::ST_FILL))
		else $error("drain started without a completed group or end flag");
`endif

endmodule

// ===== hw/rtl/group_reverse_reorder_core.sv =====
// The first result of a run appears in the cycle after the transaction that completes
// the group or carries sequence_end; the other results of the run follow without a gap.
// No new element is taken while a run drains (busy is high), since the single LIFO
// cell chain either fills or drains.
// Reset clears the element count, the drain state and the group size (to 1); the cell
// contents are not reset. The receiver cannot stall: each result shows for one cycle.
module group_reverse_reorder_core #(
	parameter int MAX_GROUP = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  grr_pkg::grr_item_t         item,
	output logic                       result_strobe,
	output grr_pkg::grr_result_t       result,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [grr_pkg::CFG_W-1:0]  cfg_data
);

	// The buffer is a chain of cells acting as a stack. Cell 0 is the top:
	// a push moves every element one cell deeper and loads the new element
	// into cell 0, while a pop moves every element one cell toward the top.
	// Reading cell 0 during a drain therefore gives the group newest first,
	// which is exactly the reversed order.

	grr_pkg::grr_shift_t               shift;
	grr_pkg::grr_status_t              status;
	logic signed [grr_pkg::DATA_W-1:0] cell_val [MAX_GROUP];

	// The group size register may be written at any time; the surrounding
	// system only writes it while no run is in progress.
	assign cfg_ready = 1'b1;

	grr_ctrl #(
		.MAX_GROUP (MAX_GROUP)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item_end  (item.sequence_end),
		.cfg_write (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.shift     (shift),
		.status    (status)
	);

	// Build the chain. The first cell takes the incoming element on a push,
	// and the deepest cell loads zero on a pop; that slot is never read
	// before a later push overwrites it.
	for (genvar i = 0; i < MAX_GROUP; i++) begin : g_cell
		logic signed [grr_pkg::DATA_W-1:0] left_val;
		logic signed [grr_pkg::DATA_W-1:0] right_val;

		if (i == 0) begin : g_head
			assign left_val = item.element_value;
		end else begin : g_body
			assign left_val = cell_val[i-1];
		end

		if (i == MAX_GROUP - 1) begin : g_tail
			assign right_val = '0;
		end else begin : g_inner
			assign right_val = cell_val[i+1];
		end

		grr_cell u_cell (
			.clk        (clk),
			.shift      (shift),
			.from_left  (left_val),
			.from_right (right_val),
			.value      (cell_val[i])
		);
	end

	// Results come straight from the top cell and the controller's
	// registered state, so no extra output stage is needed.
	assign busy                    = status.busy;
	assign result_strobe           = status.strobe;
	assign result.out_value        = cell_val[0];
	assign result.run_last         = status.run_last;
	assign result.out_sequence_end = status.seq_end;

endmodule

// ===== verif/group_reverse_reorder_core_test.sv =====
module group_reverse_reorder_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_GROUP    = 64;
	// Number of random elements sent after the directed tests.
	localparam int RANDOM_ITEMS = 220;
	// Idle cycles allowed after the last expected result before the block counts as quiet.
	localparam int SETTLE_CYCLES = 4;

	logic                                clk       = 1'b0;
	logic                                arst_n    = 1'b0;
	logic                                start     = 1'b0;
	logic                                busy;
	grr_pkg::grr_item_t                  item      = '0;
	logic                                result_strobe;
	grr_pkg::grr_result_t                result;
	logic                                cfg_valid = 1'b0;
	logic                                cfg_ready;
	logic [grr_pkg::CFG_W-1:0]           cfg_data  = '0;

	// Shadow of the block: the current group size register, the elements held so far
	// and the results that the block still owes, oldest first.
	logic [grr_pkg::CFG_W-1:0]           size_setting;
	logic signed [grr_pkg::DATA_W-1:0]   held_values [MAX_GROUP];
	int unsigned                         held_count;
	grr_pkg::grr_result_t                reordered_expect[$];

	int unsigned error_count    = 0;
	int unsigned items_sent     = 0;
	int unsigned results_seen   = 0;
	int unsigned settings_used  = 0;
	int unsigned burst_left     = 0;

	group_reverse_reorder_core #(
		.MAX_GROUP(MAX_GROUP)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_strobe(result_strobe),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always #1 clk = ~clk;

	// A setting of zero behaves as one, and anything above the buffer depth is
	// clipped to the buffer depth.
	function automatic int unsigned effective_group_size(
		input logic [grr_pkg::CFG_W-1:0] setting);
		if (setting == '0) begin
			return 1;
		end
		if (setting > MAX_GROUP) begin
			return MAX_GROUP;
		end
		return 32'(setting);
	endfunction

	// Buffers one accepted element. When the buffer reaches the group size, or the
	// element closes the sequence, everything held is owed back newest first; the last
	// result of that run carries run_last, and also the end flag when the sequence closed.
	function automatic void predict_reorder(input logic signed [grr_pkg::DATA_W-1:0] value,
	                                        input logic seq_end);
		grr_pkg::grr_result_t owed;
		int unsigned group_limit;
		int unsigned run_length;
		group_limit = effective_group_size(size_setting);
		held_values[held_count] = value;
		held_count++;
		if (held_count < group_limit && !seq_end) begin
			return;
		end
		run_length = held_count;
		for (int unsigned i = 0; i < run_length; i++) begin
			owed.out_value        = held_values[run_length - 1 - i];
			owed.run_last         = (i + 1 == run_length);
			owed.out_sequence_end = (i + 1 == run_length) && seq_end;
			reordered_expect.insert(reordered_expect.size(), owed);
		end
		held_count = 0;
	endfunction

	// Every strobed result is matched against the oldest owed result. The receiver
	// cannot hold results off, so the check runs on every edge with the strobe high.
	task automatic check_reordered_result(input grr_pkg::grr_result_t actual);
		grr_pkg::grr_result_t owed;
		results_seen++;
		if (reordered_expect.size() == 0) begin
			$display("%0t: unexpected result, value %0d run_last %0b end %0b", $time,
				actual.out_value, actual.run_last, actual.out_sequence_end);
			error_count++;
			return;
		end
		owed = reordered_expect.pop_front();
		if (actual.out_value !== owed.out_value) begin
			$display("%0t: out_value expected %0d, actual %0d", $time,
				owed.out_value, actual.out_value);
			error_count++;
		end
		if (actual.run_last !== owed.run_last) begin
			$display("%0t: run_last expected %0b, actual %0b", $time,
				owed.run_last, actual.run_last);
			error_count++;
		end
		if (actual.out_sequence_end !== owed.out_sequence_end) begin
			$display("%0t: out_sequence_end expected %0b, actual %0b", $time,
				owed.out_sequence_end, actual.out_sequence_end);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && result_strobe) begin
			check_reordered_result(result);
		end
	end

	// Burst lengths are mostly short, with an occasional long stretch of back-to-back
	// transactions so that the block also sees its full rate.
	function automatic int unsigned pick_burst();
		if ($urandom_range(0, 3) == 0) begin
			return $urandom_range(20, 60);
		end
		return $urandom_range(0, 8);
	endfunction

	// Mostly fully random data, with the extremes of the signed range mixed in.
	function automatic logic signed [grr_pkg::DATA_W-1:0] random_value();
		case ($urandom_range(0, 11))
			0: return {1'b1, {(grr_pkg::DATA_W-1){1'b0}}};
			1: return {1'b0, {(grr_pkg::DATA_W-1){1'b1}}};
			2: return '0;
			3: return '1;
			default: return grr_pkg::DATA_W'($urandom);
		endcase
	endfunction

	// Presents one element and holds it until the block takes it. Start stays high
	// within a burst; at the end of a burst it drops for a random gap.
	task automatic send_element(input logic signed [grr_pkg::DATA_W-1:0] value,
	                            input logic seq_end);
		int unsigned gap;
		start <= 1'b1;
		item  <= '{element_value: value, sequence_end: seq_end};
		do @(posedge clk); while (busy);
		predict_reorder(value, seq_end);
		items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 6);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = pick_burst();
		end
	endtask

	task automatic send_sequence(input int unsigned length, input logic close);
		for (int unsigned i = 0; i < length; i++) begin
			send_element(random_value(), close && (i + 1 == length));
		end
	endtask

	// Stops the stimulus and waits until every owed result has come back and anything
	// still in flight has settled.
	task automatic settle_block();
		start <= 1'b0;
		while (reordered_expect.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Only called while the block is quiet. Elements still held keep their place; the
	// new size decides when they flush.
	task automatic write_group_size(input logic [grr_pkg::CFG_W-1:0] setting);
		cfg_valid <= 1'b1;
		cfg_data  <= setting;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid    <= 1'b0;
		size_setting  = setting;
		settings_used++;
	endtask

	// Out of reset the group size is one, so every element comes straight back with
	// run_last set. The extremes of the data field go through here.
	task automatic test_reset_pass_through();
		send_element({1'b1, {(grr_pkg::DATA_W-1){1'b0}}}, 1'b0);
		send_element({1'b0, {(grr_pkg::DATA_W-1){1'b1}}}, 1'b0);
		send_element('0, 1'b1);
		send_element('1, 1'b1);
		settle_block();
	endtask

	// Two full groups of three and a short tail closed by the end flag, then a setting
	// of zero, which must behave as one.
	task automatic test_small_groups();
		write_group_size(7'd3);
		send_sequence(7, 1'b1);
		settle_block();
		write_group_size(7'd0);
		send_element(random_value(), 1'b0);
		send_element(random_value(), 1'b1);
		settle_block();
	endtask

	// Three elements held under a size of five; after shrinking the size to two, the
	// next element flushes all four at once. Then the opposite way: one element held
	// under two, the size grows to four and the group completes at four.
	task automatic test_resize_mid_group();
		write_group_size(7'd5);
		send_sequence(3, 1'b0);
		settle_block();
		write_group_size(7'd2);
		send_element(random_value(), 1'b0);
		send_element(random_value(), 1'b0);
		settle_block();
		write_group_size(7'd4);
		send_sequence(3, 1'b0);
		settle_block();
	endtask

	// The largest settings: all ones in the register clips to the buffer depth, and a
	// full buffer that also closes the sequence gives one run with both flags on its
	// last result. Then a short tail under the exact maximum.
	task automatic test_largest_groups();
		write_group_size(7'd127);
		send_sequence(MAX_GROUP, 1'b1);
		settle_block();
		write_group_size(grr_pkg::CFG_W'(MAX_GROUP));
		send_sequence(8, 1'b1);
		settle_block();
	endtask

	// Phases under random settings, mostly small. Most traffic is whole sequences
	// closed by the end flag; some single elements with a random flag act as noise,
	// and some phases end with a sequence left open so the next setting inherits it.
	task automatic test_random_sequences();
		int unsigned first_item;
		int unsigned length_cap;
		logic [grr_pkg::CFG_W-1:0] setting;
		first_item = items_sent;
		while (items_sent - first_item < RANDOM_ITEMS) begin
			settle_block();
			if ($urandom_range(0, 9) == 0) begin
				setting = grr_pkg::CFG_W'($urandom_range(0, 127));
			end else begin
				setting = grr_pkg::CFG_W'($urandom_range(1, 12));
			end
			write_group_size(setting);
			length_cap = 3 * effective_group_size(setting) + 2;
			if (length_cap > 20) begin
				length_cap = 20;
			end
			repeat ($urandom_range(2, 5)) begin
				if ($urandom_range(0, 7) == 0) begin
					send_element(random_value(), 1'($urandom_range(0, 1)));
				end else begin
					send_sequence($urandom_range(1, length_cap), 1'b1);
				end
			end
			if ($urandom_range(0, 2) == 0) begin
				send_sequence($urandom_range(1, 4), 1'b0);
			end
		end
		send_sequence($urandom_range(1, 6), 1'b1);
		settle_block();
	endtask

	initial begin
		size_setting = 7'd1;
		held_count   = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		burst_left = pick_burst();

		test_reset_pass_through();
		test_small_groups();
		test_resize_mid_group();
		test_largest_groups();
		test_random_sequences();

		$display("Sent %0d elements under %0d group size settings, zero up to all ones.",
			items_sent, settings_used + 1);
		$display("Checked %0d reordered results, %0d mismatches.", results_seen, error_count);
		if (error_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// The time limit leaves a wide margin over a correct run.
	initial begin
		#200000;
		$display("Timeout with %0d results still owed.", reordered_expect.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/grr_pkg.sv
hw/rtl/grr_cell.sv
hw/rtl/grr_ctrl.sv
hw/rtl/group_reverse_reorder_core.sv
verif/group_reverse_reorder_core_test.sv
